// ===== rtl/core/dbpwm_pkg.sv =====
`default_nettype none

package dbpwm_pkg;

    localparam int PERIOD_BITS        = 32;
    localparam int DUTY_FRACTION_BITS = 16;
    localparam int VALUE_W            = 32;
    localparam int CMD_W              = 3;
    localparam int DUTY_W             = DUTY_FRACTION_BITS + 1;
    localparam int PROD_W             = PERIOD_BITS + DUTY_W;

    localparam logic [PERIOD_BITS-1:0] INIT_PERIOD = PERIOD_BITS'(1000);
    localparam logic [DUTY_W-1:0] DUTY_ONE  = DUTY_W'(1) << DUTY_FRACTION_BITS;
    localparam logic [DUTY_W-1:0] DUTY_HALF = DUTY_W'(1) << (DUTY_FRACTION_BITS - 1);

    localparam longint INIT_THR_L =
        (1000 * (longint'(1) << (DUTY_FRACTION_BITS - 1))
         + (longint'(1) << (DUTY_FRACTION_BITS - 1))) >> DUTY_FRACTION_BITS;
    localparam logic [PERIOD_BITS-1:0] INIT_THR = PERIOD_BITS'(INIT_THR_L);

    localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET_PERIOD = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SET_DUTY   = 3'd4;

    typedef enum logic [1:0] {
        LVL_STOP = 2'd0,
        LVL_LOW  = 2'd1,
        LVL_HIGH = 2'd2
    } level_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] value;
        logic               finish_current;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0] level;
        logic       level_changed;
        logic       rejected;
    } res_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/dbpwm_thr.sv =====
`default_nettype none

module dbpwm_thr
    import dbpwm_pkg::*;
(
    input  wire logic [PERIOD_BITS-1:0] period,
    input  wire logic [DUTY_W-1:0]      duty,
    input  wire logic                   start_low,
    output logic      [PERIOD_BITS-1:0] thr
);

    logic [DUTY_W-1:0] frac;
    logic [PROD_W-1:0] prod;

    // first phase fraction, rounded half up after scaling by the period
    assign frac = start_low ? (DUTY_ONE - duty) : duty;
    assign prod = PROD_W'(period) * PROD_W'(frac) + PROD_W'(DUTY_HALF);
    assign thr  = PERIOD_BITS'(prod >> DUTY_FRACTION_BITS);

endmodule

`default_nettype wire

// ===== rtl/core/dbpwm_core.sv =====
`default_nettype none

module dbpwm_core
    import dbpwm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_accept,
    input  wire cmd_item_t cmd_item,
    input  wire logic      cfg_we,
    input  wire logic      cfg_data,
    output res_item_t      res_item,
    output logic           refresh
);

    logic [PERIOD_BITS-1:0] act_period_reg, act_period_next;
    logic [PERIOD_BITS-1:0] pend_period_reg, pend_period_next;
    logic [DUTY_W-1:0]      act_duty_reg, act_duty_next;
    logic [DUTY_W-1:0]      pend_duty_reg, pend_duty_next;
    logic [PERIOD_BITS-1:0] thr_reg, thr_next;
    logic [PERIOD_BITS-1:0] elapsed_reg, elapsed_next;
    level_t                 level_reg, level_next;
    logic                   mode_reg, mode_next;
    logic                   refresh_reg, refresh_next;

    logic [PERIOD_BITS-1:0] elapsed_inc;
    logic [PERIOD_BITS-1:0] mul_period;
    logic [DUTY_W-1:0]      mul_duty;
    logic                   mul_mode;
    logic [PERIOD_BITS-1:0] thr_calc;
    logic                   running;
    logic                   new_cycle;
    logic                   rejected;
    logic                   too_wide;

    function automatic level_t eval_level(input logic [DUTY_W-1:0] duty,
                                          input logic first, input logic start_low);
        level_t lv;
        if (duty == DUTY_ONE)
            lv = LVL_HIGH;
        else if (duty == '0)
            lv = LVL_LOW;
        else if (first ^ start_low)
            lv = LVL_HIGH;
        else
            lv = LVL_LOW;
        return lv;
    endfunction

    assign running     = (level_reg != LVL_STOP);
    assign elapsed_inc = elapsed_reg + PERIOD_BITS'(1);
    assign too_wide    = (VALUE_W'(cmd_item.value >> PERIOD_BITS) != '0);

    // a mode write rescales the running cycle, otherwise the multiplier serves a new cycle
    assign mul_period = cfg_we ? act_period_reg : pend_period_next;
    assign mul_duty   = cfg_we ? act_duty_reg : pend_duty_next;
    assign mul_mode   = cfg_we ? cfg_data : mode_reg;

    dbpwm_thr u_thr (
        .period    (mul_period),
        .duty      (mul_duty),
        .start_low (mul_mode),
        .thr       (thr_calc)
    );

    // shadow copies take accepted values ahead of the multiplier
    always_comb
    begin
        pend_period_next = pend_period_reg;
        pend_duty_next   = pend_duty_reg;

        if (!cfg_we && !refresh_reg && cmd_accept)
        begin
            case (cmd_item.cmd)
                CMD_SET_PERIOD:
                begin
                    if (cmd_item.value != '0 && !too_wide)
                        pend_period_next = PERIOD_BITS'(cmd_item.value);
                end
                CMD_SET_DUTY:
                begin
                    if (cmd_item.value <= VALUE_W'(DUTY_ONE))
                        pend_duty_next = DUTY_W'(cmd_item.value);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        act_period_next  = act_period_reg;
        act_duty_next    = act_duty_reg;
        thr_next         = thr_reg;
        elapsed_next     = elapsed_reg;
        level_next       = level_reg;
        mode_next        = mode_reg;
        refresh_next     = 1'b0;
        new_cycle        = 1'b0;
        rejected         = 1'b0;

        if (cfg_we)
        begin
            mode_next    = cfg_data;
            thr_next     = thr_calc;
            refresh_next = 1'b1;
        end
        else if (refresh_reg)
        begin
            // settle the level against the rescaled threshold
            if (running)
                level_next = eval_level(act_duty_reg, elapsed_reg < thr_reg, mode_reg);
        end
        else if (cmd_accept)
        begin
            case (cmd_item.cmd)
                CMD_TICK:
                begin
                    if (running)
                    begin
                        if (elapsed_inc >= act_period_reg)
                            new_cycle = 1'b1;
                        else
                        begin
                            elapsed_next = elapsed_inc;
                            level_next   = eval_level(act_duty_reg, elapsed_inc < thr_reg,
                                                      mode_reg);
                        end
                    end
                end
                CMD_START:
                begin
                    if (!running)
                        new_cycle = 1'b1;
                end
                CMD_STOP:
                begin
                    if (running)
                    begin
                        elapsed_next = '0;
                        level_next   = LVL_STOP;
                    end
                end
                CMD_SET_PERIOD:
                begin
                    if (cmd_item.value == '0 || too_wide)
                        rejected = 1'b1;
                    else if (!cmd_item.finish_current && running)
                        new_cycle = 1'b1;
                end
                CMD_SET_DUTY:
                begin
                    if (cmd_item.value > VALUE_W'(DUTY_ONE))
                        rejected = 1'b1;
                    else if (!cmd_item.finish_current && running)
                        new_cycle = 1'b1;
                end
                default:
                begin
                end
            endcase

            // apply the shadow copies; at elapsed zero the first phase holds iff thr > 0
            if (new_cycle)
            begin
                act_period_next = pend_period_next;
                act_duty_next   = pend_duty_next;
                thr_next        = thr_calc;
                elapsed_next    = '0;
                level_next      = eval_level(pend_duty_next, thr_calc != '0, mode_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_period_reg  <= INIT_PERIOD;
            pend_period_reg <= INIT_PERIOD;
            act_duty_reg    <= DUTY_HALF;
            pend_duty_reg   <= DUTY_HALF;
            thr_reg         <= INIT_THR;
            elapsed_reg     <= '0;
            level_reg       <= LVL_STOP;
            mode_reg        <= 1'b0;
            refresh_reg     <= 1'b0;
        end
        else
        begin
            act_period_reg  <= act_period_next;
            pend_period_reg <= pend_period_next;
            act_duty_reg    <= act_duty_next;
            pend_duty_reg   <= pend_duty_next;
            thr_reg         <= thr_next;
            elapsed_reg     <= elapsed_next;
            level_reg       <= level_next;
            mode_reg        <= mode_next;
            refresh_reg     <= refresh_next;
        end
    end

    assign res_item.level         = level_next;
    assign res_item.level_changed = (level_next != level_reg);
    assign res_item.rejected      = rejected;
    assign refresh                = refresh_reg;

endmodule

`default_nettype wire

// ===== rtl/core/dbpwm_skid.sv =====
`default_nettype none

module dbpwm_skid
    import dbpwm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire res_item_t push_item,
    output logic           full,
    output logic           res_valid,
    input  wire logic      res_stall,
    output res_item_t      res_item
);

    res_item_t  mem [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic       pop;

    assign pop       = res_valid && !res_stall;
    assign res_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign res_item  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

// ===== rtl/core/double_buffered_pwm_generator.sv =====
// channel | handshake            | beat
// --------+----------------------+-------------------------------------------
// cmd     | cmd_valid, cmd_stall | cmd_item: cmd, value, finish_current
// res     | res_valid, res_stall | res_item: level, level_changed, rejected
// cfg     | cfg_valid, cfg_ready | cfg_data: start_low_mode
//
// One command beat is taken every cycle while cmd_stall is low; its result is
// registered in the result buffer. The period threshold multiplier sits between
// the state registers, so a cycle restart does not stall commands. A mode write
// stalls commands in its own cycle and in the one after, while the level
// settles against the new threshold. Otherwise cmd_stall rises only when the
// two-beat result buffer is full. Reset is asynchronous, active low.
`default_nettype none

module double_buffered_pwm_generator
    import dbpwm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_stall,
    input  wire cmd_item_t cmd_item,
    output logic           res_valid,
    input  wire logic      res_stall,
    output res_item_t      res_item,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic      cfg_data
);

    logic      cmd_accept;
    logic      cfg_we;
    logic      full;
    logic      refresh;
    res_item_t core_res;

    assign cfg_ready  = 1'b1;
    assign cfg_we     = cfg_valid && cfg_ready;
    // hold commands while the result buffer is full or a mode write is pending or settling
    assign cmd_stall  = full || refresh || cfg_valid;
    assign cmd_accept = cmd_valid && !cmd_stall;

    dbpwm_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_accept (cmd_accept),
        .cmd_item   (cmd_item),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .res_item   (core_res),
        .refresh    (refresh)
    );

    dbpwm_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_accept),
        .push_item (core_res),
        .full      (full),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

endmodule

`default_nettype wire

// ===== rtl/core/dbpwm_chk.sv =====
`default_nettype none

module dbpwm_chk
    import dbpwm_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      cmd_valid,
    input wire logic      cmd_stall,
    input wire logic      res_valid,
    input wire logic      res_stall,
    input wire res_item_t res_item,
    input wire logic      cfg_valid,
    input wire logic      cfg_ready
);

    // a stalled result beat holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_item))
        else $error("result beat changed under stall");

    // every accepted command leaves a result waiting in the next cycle
    a_res_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> res_valid)
        else $error("accepted command produced no result");

    // a refused value leaves the level untouched
    a_reject_still: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.rejected |-> !res_item.level_changed)
        else $error("rejected command changed the level");

    // commands stall in the cycle after a mode write
    a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> cmd_stall)
        else $error("command taken while mode write settles");

endmodule

bind double_buffered_pwm_generator dbpwm_chk u_chk (.*);

`default_nettype wire
